[rtl/mmpd_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// mmpd_pkg
// Shared types, constants and helper functions of the min/max peak decimator.
// ============================================================================
package mmpd_pkg;

    // Field widths.
    localparam int LEN_W     = 17;
    localparam int TRACK_W   = 6;
    localparam int SAMPLE_W  = 24;
    localparam int PIX_W     = 13;
    localparam int QSEL_W    = 3;
    localparam int KIND_W    = 2;
    localparam int REM_W     = 12;
    localparam int THR_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;

    // Limits.
    localparam int MAX_BLOCK    = 65536;
    localparam int MAX_PIXELS   = 4096;
    localparam int MIN_DECIMATE = 64;
    localparam int QUEUE_DEPTH  = 4;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PIXELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_MODE  = 1'd1;
    localparam logic [PIX_W-1:0]     TARGET_PIXELS_RST = 13'd1024;
    localparam logic [QSEL_W-1:0]    QUALITY_MODE_RST  = 3'd0;

    // Input commands.
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_PASS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MIN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MAX  = 2'd2;

    // Quality selects.
    localparam logic [QSEL_W-1:0] QSEL_HIGHEST  = 3'd0;
    localparam logic [QSEL_W-1:0] QSEL_HIGH     = 3'd1;
    localparam logic [QSEL_W-1:0] QSEL_BALANCED = 3'd2;
    localparam logic [QSEL_W-1:0] QSEL_PERF     = 3'd3;
    localparam logic [QSEL_W-1:0] QSEL_MAXIMUM  = 3'd4;

    // Operation handed from the front to the back.
    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_ACC   = 2'd1,
        OP_CLOSE = 2'd2
    } t_op;

    // Block mode, one-hot.
    typedef enum logic [3:0] {
        BM_IDLE   = 4'b0001,
        BM_BYPASS = 4'b0010,
        BM_COPY   = 4'b0100,
        BM_MINMAX = 4'b1000
    } t_block_mode;

    // One queue entry.
    typedef struct packed {
        t_op                         op;
        logic                        first;
        logic signed [SAMPLE_W-1:0]  value;
        logic                        decim;
        logic                        last;
        logic [TRACK_W-1:0]          track;
    } t_qentry;

    // Density threshold in tenths; unknown selects act as "maximum".
    function automatic logic [THR_W-1:0] thr_tenths(input logic [QSEL_W-1:0] q);
        logic [THR_W-1:0] t;
        case (q)
            QSEL_HIGHEST:  t = 5'd20;
            QSEL_HIGH:     t = 5'd15;
            QSEL_BALANCED: t = 5'd12;
            QSEL_PERF:     t = 5'd10;
            default:       t = 5'd8;
        endcase
        return t;
    endfunction

endpackage

[rtl/mmpd_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// mmpd_front
// Accepts commands, sets up a block with an iterative divider and classifies
// each sample into a pass, accumulate or bin-close operation.
// ============================================================================
module mmpd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_command,
    input  logic [mmpd_pkg::LEN_W-1:0]          i_block_length,
    input  logic [mmpd_pkg::TRACK_W-1:0]        i_track_id,
    input  logic signed [mmpd_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic [mmpd_pkg::PIX_W-1:0]          i_target_pixels,
    input  logic [mmpd_pkg::QSEL_W-1:0]         i_quality_mode,
    input  logic                                i_full,
    output logic                                o_push,
    output mmpd_pkg::t_qentry                   o_entry
);

    localparam int LW = mmpd_pkg::LEN_W;
    localparam int PW = mmpd_pkg::PIX_W;
    localparam int RW = mmpd_pkg::REM_W;
    localparam int CW = $clog2(mmpd_pkg::LEN_W + 1);
    localparam int PRODW = LW + 4;

    typedef enum logic [1:0] {
        FS_READY  = 2'b01,
        FS_DIVIDE = 2'b10
    } t_front_state;

    t_front_state              r_state;
    mmpd_pkg::t_block_mode     r_mode;
    logic [LW-1:0]             r_seen;
    logic [LW-1:0]             r_total;
    logic [LW-1:0]             r_limit;
    logic [PW-1:0]             r_pixels;
    logic [mmpd_pkg::TRACK_W-1:0] r_track;
    logic                      r_bypass;
    logic [LW-1:0]             r_step_q;
    logic [RW-1:0]             r_step_r;
    logic [LW-1:0]             r_end_q;
    logic [RW-1:0]             r_end_r;
    logic [PW-1:0]             r_bins_done;
    logic                      r_bin_open;
    logic [PW-1:0]             r_div_rem;
    logic [LW-1:0]             r_div_quo;
    logic [CW-1:0]             r_div_cnt;

    logic                      w_accept;
    logic [LW-1:0]             w_n;
    logic [PW-1:0]             w_t;
    logic [PRODW-1:0]          w_len_x10;
    logic [PRODW-1:0]          w_thr_x_t;
    logic [PW-1:0]             w_rem_sh;
    logic                      w_ge;
    logic [PW-1:0]             n_div_rem;
    logic [LW-1:0]             n_div_quo;
    logic [LW-1:0]             w_seen_nx;
    logic                      w_close;
    logic [PW:0]               w_end_r_sum;
    logic [PW-1:0]             w_bins_nx;

    assign o_ready  = (r_state == FS_READY) && !i_full;
    assign w_accept = i_valid && o_ready;

    // Saturated block length and pixel count (zero raised to one) at a start.
    always_comb begin
        w_n = (i_block_length > LW'(mmpd_pkg::MAX_BLOCK)) ? LW'(mmpd_pkg::MAX_BLOCK)
                                                         : i_block_length;
        if (i_target_pixels == '0) begin
            w_t = PW'(1);
        end else if (i_target_pixels > PW'(mmpd_pkg::MAX_PIXELS)) begin
            w_t = PW'(mmpd_pkg::MAX_PIXELS);
        end else begin
            w_t = i_target_pixels;
        end
    end

    assign w_len_x10 = (PRODW'(w_n) << 3) + (PRODW'(w_n) << 1);
    assign w_thr_x_t = PRODW'(mmpd_pkg::thr_tenths(i_quality_mode)) * PRODW'(w_t);

    // One restoring division step per cycle.
    assign w_rem_sh  = {r_div_rem[PW-2:0], r_div_quo[LW-1]};
    assign w_ge      = (w_rem_sh >= r_pixels);
    assign n_div_rem = w_ge ? (w_rem_sh - r_pixels) : w_rem_sh;
    assign n_div_quo = {r_div_quo[LW-2:0], w_ge};

    // Sample classification.
    assign w_seen_nx   = r_seen + LW'(1);
    assign w_close     = (w_seen_nx == r_end_q);
    assign w_end_r_sum = (PW+1)'(r_end_r) + (PW+1)'(r_step_r);
    assign w_bins_nx   = r_bins_done + PW'(1);

    always_comb begin
        o_push        = 1'b0;
        o_entry.op    = mmpd_pkg::OP_PASS;
        o_entry.first = !r_bin_open;
        o_entry.value = i_sample_value;
        o_entry.decim = 1'b1;
        o_entry.last  = 1'b0;
        o_entry.track = r_track;
        if (w_accept && (i_command == mmpd_pkg::CMD_SAMPLE)) begin
            case (r_mode)
                mmpd_pkg::BM_BYPASS: begin
                    o_push        = 1'b1;
                    o_entry.decim = 1'b0;
                    o_entry.last  = (w_seen_nx == r_total);
                end
                mmpd_pkg::BM_COPY: begin
                    o_push       = (r_seen < r_limit);
                    o_entry.last = (w_seen_nx == r_limit);
                end
                mmpd_pkg::BM_MINMAX: begin
                    o_push       = 1'b1;
                    o_entry.op   = w_close ? mmpd_pkg::OP_CLOSE : mmpd_pkg::OP_ACC;
                    o_entry.last = (w_bins_nx == r_pixels);
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_READY;
            r_mode  <= mmpd_pkg::BM_IDLE;
        end else begin
            case (r_state)
                FS_READY: begin
                    if (w_accept && (i_command == mmpd_pkg::CMD_START)) begin
                        r_state    <= FS_DIVIDE;
                        r_mode     <= mmpd_pkg::BM_IDLE;
                        r_pixels   <= w_t;
                        r_track    <= i_track_id;
                        r_total    <= w_n;
                        r_limit    <= (w_n < LW'(w_t)) ? w_n : LW'(w_t);
                        r_seen     <= '0;
                        r_bins_done <= '0;
                        r_bin_open <= 1'b0;
                        r_bypass   <= (w_n < LW'(mmpd_pkg::MIN_DECIMATE)) ||
                                      (w_len_x10 <= w_thr_x_t);
                        r_div_rem  <= '0;
                        r_div_quo  <= w_n;
                        r_div_cnt  <= CW'(LW);
                    end else if (w_accept && (r_mode != mmpd_pkg::BM_IDLE)) begin
                        r_seen <= w_seen_nx;
                        if (w_seen_nx == r_total) begin
                            r_mode <= mmpd_pkg::BM_IDLE;
                        end
                        if (r_mode == mmpd_pkg::BM_MINMAX) begin
                            r_bin_open <= !w_close;
                            if (w_close) begin
                                r_bins_done <= w_bins_nx;
                                if (w_end_r_sum >= (PW+1)'(r_pixels)) begin
                                    r_end_r <= RW'(w_end_r_sum - (PW+1)'(r_pixels));
                                    r_end_q <= r_end_q + r_step_q + LW'(1);
                                end else begin
                                    r_end_r <= RW'(w_end_r_sum);
                                    r_end_q <= r_end_q + r_step_q;
                                end
                            end
                        end
                    end
                end
                FS_DIVIDE: begin
                    r_div_rem <= n_div_rem;
                    r_div_quo <= n_div_quo;
                    r_div_cnt <= r_div_cnt - CW'(1);
                    if (r_div_cnt == CW'(1)) begin
                        r_state  <= FS_READY;
                        r_step_q <= n_div_quo;
                        r_step_r <= RW'(n_div_rem);
                        r_end_q  <= n_div_quo;
                        r_end_r  <= RW'(n_div_rem);
                        if (r_total == '0) begin
                            r_mode <= mmpd_pkg::BM_IDLE;
                        end else if (r_bypass) begin
                            r_mode <= mmpd_pkg::BM_BYPASS;
                        end else if (n_div_quo <= LW'(1)) begin
                            r_mode <= mmpd_pkg::BM_COPY;
                        end else begin
                            r_mode <= mmpd_pkg::BM_MINMAX;
                        end
                    end
                end
                default: begin
                    r_state <= FS_READY;
                end
            endcase
        end
    end

endmodule

[rtl/mmpd_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// mmpd_queue
// Short register queue of classified samples between front and back.
// ============================================================================
module mmpd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mmpd_pkg::t_qentry i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output mmpd_pkg::t_qentry o_entry
);

    localparam int DEPTH = mmpd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mmpd_pkg::t_qentry r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_entry   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/mmpd_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// mmpd_back
// Carries out queued operations: passes samples, keeps the running bin
// minimum and maximum, and emits min then max when a bin closes.
// ============================================================================
module mmpd_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  mmpd_pkg::t_qentry                    i_entry,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [mmpd_pkg::SAMPLE_W-1:0] o_out_value,
    output logic [mmpd_pkg::KIND_W-1:0]          o_value_kind,
    output logic                                 o_was_decimated,
    output logic [mmpd_pkg::TRACK_W-1:0]         o_out_track,
    output logic                                 o_is_last
);

    localparam int SW = mmpd_pkg::SAMPLE_W;

    logic signed [SW-1:0]             r_min;
    logic signed [SW-1:0]             r_max;
    logic                             r_max_phase;
    logic                             r_out_valid;
    logic signed [SW-1:0]             r_out_value;
    logic [mmpd_pkg::KIND_W-1:0]      r_out_kind;
    logic                             r_out_decim;
    logic [mmpd_pkg::TRACK_W-1:0]     r_out_track;
    logic                             r_out_last;

    logic                             w_can_load;
    logic                             w_load;
    logic                             w_update;
    logic signed [SW-1:0]             w_new_min;
    logic signed [SW-1:0]             w_new_max;
    logic signed [SW-1:0]             n_out_value;
    logic [mmpd_pkg::KIND_W-1:0]      n_out_kind;
    logic                             n_out_last;
    logic                             n_max_phase;

    assign w_can_load = !r_out_valid || i_ready;
    assign w_new_min  = (i_entry.first || (i_entry.value < r_min)) ? i_entry.value : r_min;
    assign w_new_max  = (i_entry.first || (i_entry.value > r_max)) ? i_entry.value : r_max;

    always_comb begin
        o_pop       = 1'b0;
        w_load      = 1'b0;
        w_update    = 1'b0;
        n_out_value = i_entry.value;
        n_out_kind  = mmpd_pkg::KIND_PASS;
        n_out_last  = i_entry.last;
        n_max_phase = r_max_phase;
        if (i_q_valid) begin
            case (i_entry.op)
                mmpd_pkg::OP_PASS: begin
                    w_load = w_can_load;
                    o_pop  = w_can_load;
                end
                mmpd_pkg::OP_ACC: begin
                    o_pop    = 1'b1;
                    w_update = 1'b1;
                end
                mmpd_pkg::OP_CLOSE: begin
                    if (!r_max_phase) begin
                        // First half: fold in the closing sample, show the minimum.
                        w_load      = w_can_load;
                        w_update    = w_can_load;
                        n_out_value = w_new_min;
                        n_out_kind  = mmpd_pkg::KIND_MIN;
                        n_out_last  = 1'b0;
                        n_max_phase = w_can_load;
                    end else begin
                        w_load      = w_can_load;
                        o_pop       = w_can_load;
                        n_out_value = r_max;
                        n_out_kind  = mmpd_pkg::KIND_MAX;
                        n_max_phase = !w_can_load;
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_min <= w_new_min;
            r_max <= w_new_max;
        end
        if (w_load) begin
            r_out_value <= n_out_value;
            r_out_kind  <= n_out_kind;
            r_out_decim <= i_entry.decim;
            r_out_track <= i_entry.track;
            r_out_last  <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_max_phase <= 1'b0;
        end else begin
            r_max_phase <= n_max_phase;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_value     = r_out_value;
    assign o_value_kind    = r_out_kind;
    assign o_was_decimated = r_out_decim;
    assign o_out_track     = r_out_track;
    assign o_is_last       = r_out_last;

endmodule

[rtl/minmax_peak_decimator_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// minmax_peak_decimator_top
// Min/max peak decimator that reduces a block of samples to display columns.
// ============================================================================
// Usage:
// The input channel (i_valid/o_ready) carries commands. A start command
// (i_command = 0) opens a block of i_block_length samples for i_track_id;
// sample commands (i_command = 1) then carry the samples in i_sample_value.
// At a start the block picks bypass (every sample passes), copy (the first
// min(N, T) samples pass) or min/max mode (each of T bins emits its minimum,
// then its maximum). Results leave on o_valid/i_ready, one per transfer.
// The configuration channel (i_cfg_valid/o_cfg_ready) writes target_pixels
// (index 0) and quality_mode (index 1); it is always ready.
// A start holds o_ready low while a one-bit-per-cycle divider computes the
// bin step N / T. A sample passes through the queue and the output register
// before its result can transfer. Bypass and copy blocks take one sample per
// cycle while the queue has room; in min/max mode the back end emits a
// minimum and a maximum per closing sample, so the four-entry queue can fill.
// When the receiver stalls, the output register holds, the queue fills and
// o_ready drops. Reset clears the output valid, the queue and the block mode
// (idle), and restores target_pixels to 1024 and quality_mode to 0.
// ============================================================================
module minmax_peak_decimator_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Command and sample input.
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_command,
    input  logic [mmpd_pkg::LEN_W-1:0]           i_block_length,
    input  logic [mmpd_pkg::TRACK_W-1:0]         i_track_id,
    input  logic signed [mmpd_pkg::SAMPLE_W-1:0] i_sample_value,
    // Result output.
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [mmpd_pkg::SAMPLE_W-1:0] o_out_value,
    output logic [mmpd_pkg::KIND_W-1:0]          o_value_kind,
    output logic                                 o_was_decimated,
    output logic [mmpd_pkg::TRACK_W-1:0]         o_out_track,
    output logic                                 o_is_last,
    // Configuration writes.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mmpd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mmpd_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    logic [mmpd_pkg::PIX_W-1:0]  r_target_pixels;
    logic [mmpd_pkg::QSEL_W-1:0] r_quality_mode;

    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_q_valid;
    mmpd_pkg::t_qentry w_push_entry;
    mmpd_pkg::t_qentry w_head_entry;

    // The register file never stalls a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pixels <= mmpd_pkg::TARGET_PIXELS_RST;
            r_quality_mode  <= mmpd_pkg::QUALITY_MODE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mmpd_pkg::CFG_TARGET_PIXELS: begin
                    r_target_pixels <= i_cfg_data[mmpd_pkg::PIX_W-1:0];
                end
                mmpd_pkg::CFG_QUALITY_MODE: begin
                    r_quality_mode <= i_cfg_data[mmpd_pkg::QSEL_W-1:0];
                end
                default: begin
                    r_quality_mode <= r_quality_mode;
                end
            endcase
        end
    end

    // Front end: block setup, divider and per-sample bin tracking.
    mmpd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_block_length  (i_block_length),
        .i_track_id      (i_track_id),
        .i_sample_value  (i_sample_value),
        .i_target_pixels (r_target_pixels),
        .i_quality_mode  (r_quality_mode),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    // Decoupling queue of classified samples.
    mmpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_head_entry)
    );

    // Back end: running min/max and the output register.
    mmpd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_entry         (w_head_entry),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_value     (o_out_value),
        .o_value_kind    (o_value_kind),
        .o_was_decimated (o_was_decimated),
        .o_out_track     (o_out_track),
        .o_is_last       (o_is_last)
    );

endmodule

[rtl/mmpd_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// mmpd_checker
// Port-level checks of the min/max peak decimator, bound to the top level.
// ============================================================================
module mmpd_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_ready,
    input  logic                                 i_command,
    input  logic [mmpd_pkg::LEN_W-1:0]           i_block_length,
    input  logic [mmpd_pkg::TRACK_W-1:0]         i_track_id,
    input  logic signed [mmpd_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic signed [mmpd_pkg::SAMPLE_W-1:0] o_out_value,
    input  logic [mmpd_pkg::KIND_W-1:0]          o_value_kind,
    input  logic                                 o_was_decimated,
    input  logic [mmpd_pkg::TRACK_W-1:0]         o_out_track,
    input  logic                                 o_is_last,
    input  logic                                 i_cfg_valid,
    input  logic                                 o_cfg_ready,
    input  logic [mmpd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mmpd_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_value) && $stable(o_value_kind)))
        else $error("result changed while stalled");

    // A bin minimum is always followed at once by its maximum, same track.
    a_min_then_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && (o_value_kind == mmpd_pkg::KIND_MIN)) |=>
        (o_valid && (o_value_kind == mmpd_pkg::KIND_MAX) && $stable(o_out_track)))
        else $error("bin minimum not followed by its maximum");

    // Bin results only come from a decimated block and a minimum never ends it.
    a_bin_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_value_kind != mmpd_pkg::KIND_PASS)) |->
        (o_was_decimated && !(o_is_last && (o_value_kind == mmpd_pkg::KIND_MIN))))
        else $error("bin result with wrong flags");

    // No result is shown right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind minmax_peak_decimator_top mmpd_checker u_mmpd_checker (.*);
